>>> sv/chs_pkg.sv
package chs_pkg;

	localparam int KEY_W = 31;
	localparam int KIND_W = 2;
	localparam int CNT_W = 7;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CNT_W-1:0] CNT_RESET = 7'd7;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_DELETE = 2'd1;
	localparam kind_t KIND_LOOKUP = 2'd2;

	localparam logic [APB_AW-1:0] ADDR_BUCKET_COUNT = 3'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ROW,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

>>> sv/chs_req_if.sv
interface chs_req_if import chs_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	key_t  key;

	modport source (output valid, output kind, output key, input ready);
	modport sink (input valid, input kind, input key, output ready);
endinterface

>>> sv/chs_rsp_if.sv
interface chs_rsp_if import chs_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	logic bucket_full;

	modport source (output valid, output found, output bucket_full, input ready);
	modport sink (input valid, input found, input bucket_full, output ready);
endinterface

>>> sv/chs_ram.sv
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/chs_mod.sv
module chs_mod import chs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  key_t dividend,
	input  cnt_t divisor,
	output logic done,
	output cnt_t remainder
);

	localparam int STEP_W = $clog2(KEY_W + 1);

	logic              active_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	key_t              dvd_q;
	cnt_t              div_q;
	cnt_t              rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              take;

	// restoring step: bring down one dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[KEY_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= STEP_W'(KEY_W);
			end else if (active_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (active_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> sv/chained_hash_set.sv
// A request is taken in the idle state, the bit-serial modulo unit reduces its key by
// the bucket count, the bucket's valid row is read, then its slots are read in turn from
// the key memory. One request is handled at a time: the next is taken after the result is
// loaded into the response register.
// Reset (arst_n, asynchronous): bucket_count returns to 7, then a clearing pass
// zeroes the slot valid rows in turn; no request is taken until it ends.
// Configuration writes are taken at any time, including during the clearing pass.
module chained_hash_set import chs_pkg::*; #(
	parameter int NUM_BUCKETS = 64,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	chs_req_if.sink           req,
	chs_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int AW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int BW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW = BUCKET_DEPTH > 1 ? $clog2(BUCKET_DEPTH) : 1;
	localparam int IW = $clog2(BUCKET_DEPTH + 1);

	state_t state_q, state_d;

	cnt_t              cnt_q;
	cnt_t              eff_cnt;
	logic [BW-1:0]     clr_idx_q;
	logic              clr_last;
	logic              out_valid_q;
	logic              out_found_q;
	logic              out_full_q;
	logic              res_found_q;
	logic              res_full_q;
	kind_t             kind_q;
	key_t              key_q;
	logic [BW-1:0]     bucket_q;
	logic [AW-1:0]     base_q;
	logic [IW-1:0]     idx_q;
	logic              chk_s1;
	logic [SW-1:0]     chk_idx_s1;

	logic              div_start;
	logic              div_done;
	cnt_t              div_rem;
	logic [31:0]       rem_ext;

	logic              vld_we;
	logic [BW-1:0]     vld_waddr;
	logic [BUCKET_DEPTH-1:0] vld_wdata;
	logic [BUCKET_DEPTH-1:0] row;
	logic [BUCKET_DEPTH-1:0] slot_mask;
	logic              key_we;
	logic [AW-1:0]     key_waddr;
	logic [AW-1:0]     key_raddr;
	key_t              key_rd;

	logic              cfg_we;
	logic              slot_v;
	logic              hit;
	logic              scan_end;
	logic              issue;
	logic              load_out;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & (paddr[APB_AW-1] == ADDR_BUCKET_COUNT[APB_AW-1]);
	assign prdata = (paddr[APB_AW-1] == ADDR_BUCKET_COUNT[APB_AW-1]) ?
		APB_DW'(cnt_q) : '0;

	// zero acts as one, oversize saturates to the bucket count
	always_comb begin
		if (cnt_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (32'(cnt_q) > 32'(NUM_BUCKETS)) begin
			eff_cnt = CNT_W'(NUM_BUCKETS);
		end else begin
			eff_cnt = cnt_q;
		end
	end

	chs_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.key),
		.divisor   (eff_cnt),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign rem_ext = 32'(div_rem);

	chs_ram #(.WIDTH(BUCKET_DEPTH), .DEPTH(NUM_BUCKETS)) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.raddr (bucket_q),
		.rdata (row)
	);

	chs_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.raddr (key_raddr),
		.rdata (key_rd)
	);

	// slot check, in the cycle after the key read is issued
	assign slot_v    = row[chk_idx_s1];
	assign slot_mask = BUCKET_DEPTH'(1) << chk_idx_s1;
	assign hit = chk_s1 && (((kind_q == KIND_INSERT) && !slot_v) ||
		(((kind_q == KIND_DELETE) || (kind_q == KIND_LOOKUP)) && slot_v && (key_rd == key_q)));
	assign scan_end = hit || (!chk_s1 && (idx_q == IW'(BUCKET_DEPTH)));
	assign issue    = idx_q != IW'(BUCKET_DEPTH);
	assign clr_last = clr_idx_q == BW'(NUM_BUCKETS - 1);
	assign load_out = !out_valid_q || rsp.ready;
	assign key_raddr = base_q + AW'(idx_q);
	assign key_waddr = base_q + AW'(chk_idx_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		div_start = 1'b0;
		vld_we    = 1'b0;
		vld_waddr = bucket_q;
		vld_wdata = row;
		key_we    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				vld_we    = 1'b1;
				vld_waddr = clr_idx_q;
				vld_wdata = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid;
			end
			ST_SCAN: begin
				if (hit && (kind_q == KIND_INSERT)) begin
					vld_we    = 1'b1;
					vld_wdata = row | slot_mask;
					key_we    = 1'b1;
				end else if (hit && (kind_q == KIND_DELETE)) begin
					vld_we    = 1'b1;
					vld_wdata = row & ~slot_mask;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= CNT_RESET;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			chk_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cnt_q <= pwdata[CNT_W-1:0];
			end
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if ((state_q == ST_DONE) && load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				chk_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end else begin
				chk_s1 <= 1'b0;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			kind_q <= req.kind;
			key_q  <= req.key;
		end
		if ((state_q == ST_DIV) && div_done) begin
			bucket_q <= rem_ext[BW-1:0];
		end
		if (state_q == ST_ROW) begin
			base_q <= AW'(32'(bucket_q) * 32'(BUCKET_DEPTH));
		end
		if ((state_q == ST_SCAN) && issue) begin
			chk_idx_s1 <= idx_q[SW-1:0];
		end
		if ((state_q == ST_SCAN) && scan_end) begin
			res_found_q <= hit && (kind_q != KIND_INSERT);
			res_full_q  <= !hit && (kind_q == KIND_INSERT);
		end
		if ((state_q == ST_DONE) && load_out) begin
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.bucket_full = out_full_q;

endmodule
